@@ design/mlpsb_pkg.sv @@
// Shared types, constants and the sigmoid table for the perceptron trainer.
// No dependencies; every other design file imports this package.
package mlpsb_pkg;

	localparam int FRAC      = 16;
	localparam int VAL_W     = 24;
	localparam int ACT_W     = 17;
	localparam int LR_W      = 23;
	localparam int PIDX_W    = 4;
	localparam int SIG_DEPTH = 1024;
	localparam int SIG_ABITS = $clog2(SIG_DEPTH);
	localparam int MUL_A_W   = 32;
	localparam int MUL_B_W   = 25;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int SH_W      = PROD_W - FRAC;
	localparam int ACC_W     = SH_W + 1;
	// Parameter store address, wide enough for sixteen hidden nodes
	localparam int PAR_AW    = 7;

	localparam logic [LR_W-1:0]  LR_RESET = 23'd327680;
	localparam logic [ACT_W-1:0] ONE_FX   = ACT_W'(1 << FRAC);

	typedef enum logic [1:0] {
		FUNC_TRAIN = 2'd0,
		FUNC_INFER = 2'd1,
		FUNC_LOAD  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef struct packed {
		logic [1:0]              func;
		logic signed [VAL_W-1:0] sample_a;
		logic signed [VAL_W-1:0] sample_b;
		logic [ACT_W-1:0]        target_value;
		logic [PIDX_W-1:0]       param_index;
		logic signed [VAL_W-1:0] param_value;
	} in_item_t;

	typedef struct packed {
		logic [ACT_W-1:0] activation;
		logic [ACT_W-1:0] squared_error;
		logic             predicted_class;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [PAR_AW-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
		logic [PAR_AW-1:0] raddr;
	} pmem_req_t;

	typedef logic [ACT_W-1:0] sig_tab_t [SIG_DEPTH];

	// Shift-subtract divide, used only while elaborating the table
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic sig_tab_t build_sig_table();
		sig_tab_t    tab;
		logic [63:0] epow [SIG_DEPTH/2+1];
		logic [63:0] s;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		logic [63:0] den;
		logic [63:0] num;
		int          j;
		s    = (64'd16 << 32) >> SIG_ABITS;
		term = 64'd1 << 32;
		sum  = 64'd1 << 32;
		for (int k = 1; k <= 24; k++) begin
			term = udiv((term * s) >> 32, 64'(k));
			if (k % 2 == 1) sum = sum - term;
			else sum = sum + term;
		end
		r = (sum >= (64'd1 << 32)) ? (64'd1 << 32) - 64'd1 : sum;
		epow[0] = 64'd1 << 32;
		for (int i = 1; i <= SIG_DEPTH/2; i++)
			epow[i] = (epow[i-1] * r + (64'd1 << 31)) >> 32;
		for (int i = 0; i < SIG_DEPTH; i++) begin
			j   = (i < SIG_DEPTH/2) ? SIG_DEPTH/2 - i : i - SIG_DEPTH/2;
			den = (64'd1 << 32) + epow[j];
			num = (i < SIG_DEPTH/2) ? epow[j] : (64'd1 << 32);
			tab[i] = ACT_W'(udiv((num << FRAC) + (den >> 1), den));
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

	// Clamp to the 24-bit signed parameter range
	function automatic logic [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'((64'sd1 <<< (VAL_W - 1)) - 64'sd1);
		lo = -hi - ACC_W'(1);
		if (v > hi) return hi[VAL_W-1:0];
		if (v < lo) return lo[VAL_W-1:0];
		return v[VAL_W-1:0];
	endfunction

endpackage

@@ design/mlpsb_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on mlpsb_pkg for operand widths.
module mlpsb_mul import mlpsb_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  prod
);

	logic signed [PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_s1;

endmodule

@@ design/mlpsb_pmem.sv @@
// Weight and bias store: one write port, one registered read port.
// Depends on mlpsb_pkg for the request struct and value width.
module mlpsb_pmem import mlpsb_pkg::*; #(
	parameter int HIDDEN_COUNT = 2
) (
	input  logic             clk,
	input  pmem_req_t        req,
	output logic [VAL_W-1:0] rdata
);

	localparam int DEPTH = 4 * HIDDEN_COUNT + 1;
	localparam int AW    = $clog2(DEPTH);

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		rdata_q <= mem[req.raddr[AW-1:0]];
	end

	assign rdata = rdata_q;

endmodule

@@ design/mlpsb_sig.sv @@
// Saturating sigmoid lookup over [-8,8), table read registered.
// Depends on mlpsb_pkg for the table and widths.
module mlpsb_sig import mlpsb_pkg::*; (
	input  logic                    clk,
	input  logic signed [ACC_W-1:0] x,
	output logic [ACT_W-1:0]        y
);

	localparam logic signed [ACC_W-1:0] LIM = ACC_W'(8 << FRAC);

	logic signed [ACC_W-1:0] xc;
	logic [ACC_W-1:0]        u;
	logic [SIG_ABITS-1:0]    idx;
	logic [ACT_W-1:0]        y_q;

	always_comb begin
		if (x < -LIM) xc = -LIM;
		else if (x > LIM - ACC_W'(1)) xc = LIM - ACC_W'(1);
		else xc = x;
		u   = xc + LIM;
		idx = u[FRAC+3 -: SIG_ABITS];
	end

	// hold the entry for the cycle after the address
	always_ff @(posedge clk) begin
		y_q <= SIG_TABLE[idx];
	end

	assign y = y_q;

endmodule

@@ design/mlp_sigmoid_backprop_step.sv @@
// Top level: 2-input, HIDDEN_COUNT-hidden, 1-output sigmoid perceptron with SGD.
// Depends on mlpsb_pkg, mlpsb_mul, mlpsb_pmem and mlpsb_sig.
//
//  channel   | ports                       | transfer
//  ----------+-----------------------------+---------------------------------
//  config    | cfg_we, cfg_wdata           | edge with cfg_we high
//  item in   | start, busy, item           | edge with start high, busy low
//  result    | done, result                | the one cycle done is high
//
// A train item keeps busy high through the forward, backward and update passes, an
// infer item through the forward pass only; done is high in the first cycle with
// busy low. A load or an unused code leaves busy low and gives done in the next
// cycle. The sequence is set by the single multiplier, the single read port of the
// parameter store and the registered sigmoid table, so products, parameter reads
// and table reads are issued one at a time. Reset clears the sequencer and sets
// the learning rate to 5.0; weights and biases are not cleared and must be
// loaded. The receiver cannot stall a result.
module mlp_sigmoid_backprop_step import mlpsb_pkg::*; #(
	parameter int HIDDEN_COUNT = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [LR_W-1:0] cfg_wdata,
	input  logic            start,
	input  in_item_t        item,
	output logic            busy,
	output logic            done,
	output result_t         result
);

	localparam int KW = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;

	typedef enum logic [5:0] {
		IDLE,
		FW_A, FW_B, FW_C, FW_D, FW_E, FW_F, FW_G,
		FW_OB, FW_OC, FW_SIG, FW_DIFF,
		BK_COST, BK_DSA, BK_DSB, BK_DOUT, BK_DOUT2,
		BK_H0, BK_H1, BK_H2, BK_H3, BK_H4,
		UP_OB0, UP_OB1,
		UP_OW0, UP_OW1, UP_OW2, UP_OW3,
		UP_HB0, UP_HB1,
		UP_HW0, UP_HW1, UP_HW2, UP_HW3
	} state_t;

	state_t                  state_q;
	logic [LR_W-1:0]         lr_q;
	logic                    done_q;
	result_t                 result_q;
	logic [1:0]              func_q;
	logic [KW-1:0]           k_q;
	logic                    i_q;
	logic signed [VAL_W-1:0] x0_q, x1_q;
	logic [ACT_W-1:0]        t_q;
	logic signed [ACC_W-1:0] acc_q, o_q;
	logic [ACT_W-1:0]        ao_q, cost_q;
	logic [ACT_W-1:0]        ah_q [HIDDEN_COUNT];
	logic signed [MUL_A_W-1:0] dh_q [HIDDEN_COUNT];
	logic signed [ACT_W:0]   diff_q;
	logic signed [MUL_B_W-1:0] tmp_q;
	logic signed [MUL_A_W-1:0] dout_q, m_q;

	logic                      accept;
	logic                      last_k;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [SH_W-1:0]    sh;
	pmem_req_t                 preq;
	logic [VAL_W-1:0]          rdata;
	logic signed [ACC_W-1:0]   sig_in;
	logic [ACT_W-1:0]          sig_out;
	logic [PAR_AW-1:0]         a_hw0, a_hw1, a_hb, a_ow, a_ob, a_hwi;
	logic [VAL_W-1:0]          upd_val;

	assign accept = start && !busy;
	assign last_k = (k_q == KW'(HIDDEN_COUNT - 1));
	assign sh     = prod[PROD_W-1:FRAC];
	// table address in FW_E and FW_SIG; the entry shows up in the next cycle
	assign sig_in = (state_q == FW_E) ? acc_q : o_q;

	// Parameter store layout follows the load index
	assign a_hw0 = PAR_AW'(k_q);
	assign a_hw1 = PAR_AW'(k_q) + PAR_AW'(HIDDEN_COUNT);
	assign a_hb  = PAR_AW'(k_q) + PAR_AW'(2 * HIDDEN_COUNT);
	assign a_ow  = PAR_AW'(k_q) + PAR_AW'(3 * HIDDEN_COUNT);
	assign a_ob  = PAR_AW'(4 * HIDDEN_COUNT);
	assign a_hwi = i_q ? a_hw1 : a_hw0;

	// Stored value minus the scaled gradient that just left the multiplier
	assign upd_val = sat_val(ACC_W'(signed'(rdata)) - ACC_W'(sh));

	mlpsb_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	mlpsb_pmem #(
		.HIDDEN_COUNT (HIDDEN_COUNT)
	) u_pmem (
		.clk   (clk),
		.req   (preq),
		.rdata (rdata)
	);

	mlpsb_sig u_sig (
		.clk (clk),
		.x   (sig_in),
		.y   (sig_out)
	);

	// Operand select, read address and write-back for each sequencer step
	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		preq.we    = 1'b0;
		preq.waddr = '0;
		preq.wdata = '0;
		preq.raddr = '0;
		unique case (state_q)
			IDLE: begin
				// load transfer writes straight into the store
				if (accept && item.func == FUNC_LOAD &&
					PAR_AW'(item.param_index) <= PAR_AW'(4 * HIDDEN_COUNT)) begin
					preq.we    = 1'b1;
					preq.waddr = PAR_AW'(item.param_index);
					preq.wdata = item.param_value;
				end
			end
			FW_A: preq.raddr = a_hw0;
			FW_B: begin
				mul_a      = MUL_A_W'(x0_q);
				mul_b      = MUL_B_W'(signed'(rdata));
				preq.raddr = a_hw1;
			end
			FW_C: begin
				mul_a      = MUL_A_W'(x1_q);
				mul_b      = MUL_B_W'(signed'(rdata));
				preq.raddr = a_hb;
			end
			FW_D, FW_E: preq.raddr = a_ow;
			FW_F: begin
				mul_a = MUL_A_W'({1'b0, sig_out});
				mul_b = MUL_B_W'(signed'(rdata));
			end
			FW_OB: preq.raddr = a_ob;
			BK_COST: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'(diff_q);
			end
			BK_DSA: begin
				mul_a = MUL_A_W'({1'b0, ao_q});
				mul_b = MUL_B_W'({1'b0, ONE_FX - ao_q});
			end
			BK_DOUT: begin
				mul_a = MUL_A_W'(diff_q) <<< 1;
				mul_b = tmp_q;
			end
			BK_H0: begin
				mul_a      = MUL_A_W'({1'b0, ah_q[k_q]});
				mul_b      = MUL_B_W'({1'b0, ONE_FX - ah_q[k_q]});
				preq.raddr = a_ow;
			end
			BK_H1: begin
				mul_a = dout_q;
				mul_b = MUL_B_W'(signed'(rdata));
			end
			BK_H3: begin
				mul_a = m_q;
				mul_b = tmp_q;
			end
			UP_OB0: begin
				mul_a      = dout_q;
				mul_b      = MUL_B_W'({1'b0, lr_q});
				preq.raddr = a_ob;
			end
			UP_OB1: begin
				preq.we    = 1'b1;
				preq.waddr = a_ob;
				preq.wdata = upd_val;
			end
			UP_OW0: begin
				mul_a      = dout_q;
				mul_b      = MUL_B_W'({1'b0, ah_q[k_q]});
				preq.raddr = a_ow;
			end
			UP_OW1: preq.raddr = a_ow;
			UP_OW2: begin
				mul_a      = m_q;
				mul_b      = MUL_B_W'({1'b0, lr_q});
				preq.raddr = a_ow;
			end
			UP_OW3: begin
				preq.we    = 1'b1;
				preq.waddr = a_ow;
				preq.wdata = upd_val;
			end
			UP_HB0: begin
				mul_a      = dh_q[k_q];
				mul_b      = MUL_B_W'({1'b0, lr_q});
				preq.raddr = a_hb;
			end
			UP_HB1: begin
				preq.we    = 1'b1;
				preq.waddr = a_hb;
				preq.wdata = upd_val;
			end
			UP_HW0: begin
				mul_a      = dh_q[k_q];
				mul_b      = i_q ? MUL_B_W'(x1_q) : MUL_B_W'(x0_q);
				preq.raddr = a_hwi;
			end
			UP_HW1: preq.raddr = a_hwi;
			UP_HW2: begin
				mul_a      = m_q;
				mul_b      = MUL_B_W'({1'b0, lr_q});
				preq.raddr = a_hwi;
			end
			UP_HW3: begin
				preq.we    = 1'b1;
				preq.waddr = a_hwi;
				preq.wdata = upd_val;
			end
			default: ;
		endcase
	end

	// Learning rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LR_RESET;
		end else if (cfg_we) begin
			lr_q <= cfg_wdata;
		end
	end

	// Sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done_q  <= 1'b0;
			k_q     <= '0;
			i_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						k_q <= '0;
						i_q <= 1'b0;
						if (item.func == FUNC_TRAIN || item.func == FUNC_INFER) begin
							state_q <= FW_A;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				FW_A:    state_q <= FW_B;
				FW_B:    state_q <= FW_C;
				FW_C:    state_q <= FW_D;
				FW_D:    state_q <= FW_E;
				FW_E:    state_q <= FW_F;
				FW_F:    state_q <= FW_G;
				FW_G: begin
					if (last_k) begin
						k_q     <= '0;
						state_q <= FW_OB;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= FW_A;
					end
				end
				FW_OB:   state_q <= FW_OC;
				FW_OC:   state_q <= FW_SIG;
				FW_SIG:  state_q <= FW_DIFF;
				FW_DIFF: begin
					if (func_q == FUNC_INFER) begin
						done_q  <= 1'b1;
						state_q <= IDLE;
					end else begin
						state_q <= BK_COST;
					end
				end
				BK_COST:  state_q <= BK_DSA;
				BK_DSA:   state_q <= BK_DSB;
				BK_DSB:   state_q <= BK_DOUT;
				BK_DOUT:  state_q <= BK_DOUT2;
				BK_DOUT2: state_q <= BK_H0;
				BK_H0:    state_q <= BK_H1;
				BK_H1:    state_q <= BK_H2;
				BK_H2:    state_q <= BK_H3;
				BK_H3:    state_q <= BK_H4;
				BK_H4: begin
					if (last_k) begin
						k_q     <= '0;
						state_q <= UP_OB0;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= BK_H0;
					end
				end
				UP_OB0: state_q <= UP_OB1;
				UP_OB1: state_q <= UP_OW0;
				UP_OW0: state_q <= UP_OW1;
				UP_OW1: state_q <= UP_OW2;
				UP_OW2: state_q <= UP_OW3;
				UP_OW3: begin
					if (last_k) begin
						k_q     <= '0;
						state_q <= UP_HB0;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= UP_OW0;
					end
				end
				UP_HB0: state_q <= UP_HB1;
				UP_HB1: begin
					i_q     <= 1'b0;
					state_q <= UP_HW0;
				end
				UP_HW0: state_q <= UP_HW1;
				UP_HW1: state_q <= UP_HW2;
				UP_HW2: state_q <= UP_HW3;
				UP_HW3: begin
					if (!i_q) begin
						i_q     <= 1'b1;
						state_q <= UP_HW0;
					end else if (last_k) begin
						i_q     <= 1'b0;
						done_q  <= 1'b1;
						state_q <= IDLE;
					end else begin
						i_q     <= 1'b0;
						k_q     <= k_q + KW'(1);
						state_q <= UP_HB0;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Datapath registers; no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			IDLE: begin
				if (accept) begin
					func_q   <= item.func;
					x0_q     <= item.sample_a;
					x1_q     <= item.sample_b;
					// clamp the target to one
					t_q      <= (item.target_value > ONE_FX) ? ONE_FX : item.target_value;
					o_q      <= '0;
					cost_q   <= '0;
					// load and unused codes report all zero
					result_q <= '0;
				end
			end
			FW_C: acc_q <= ACC_W'(sh);
			FW_D: acc_q <= acc_q + ACC_W'(sh) + ACC_W'(signed'(rdata));
			FW_F: ah_q[k_q] <= sig_out;
			FW_G: o_q <= o_q + ACC_W'(sh);
			FW_OC: o_q <= o_q + ACC_W'(signed'(rdata));
			FW_DIFF: begin
				ao_q   <= sig_out;
				diff_q <= signed'({1'b0, sig_out}) - signed'({1'b0, t_q});
				result_q.activation      <= sig_out;
				result_q.squared_error   <= '0;
				result_q.predicted_class <= (sig_out >= (ONE_FX >> 1));
			end
			BK_DSA: begin
				cost_q <= (sh > SH_W'(ONE_FX)) ? ONE_FX : sh[ACT_W-1:0];
			end
			BK_DSB:   tmp_q  <= MUL_B_W'(sh);
			BK_DOUT2: begin
				dout_q <= MUL_A_W'(sh);
				result_q.squared_error <= cost_q;
			end
			BK_H1:  tmp_q     <= MUL_B_W'(sh);
			BK_H2:  m_q       <= MUL_A_W'(sh);
			BK_H4:  dh_q[k_q] <= MUL_A_W'(sh);
			UP_OW1: m_q       <= MUL_A_W'(sh);
			UP_HW1: m_q       <= MUL_A_W'(sh);
			default: ;
		endcase
	end

	assign busy   = (state_q != IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

@@ design/mlpsb_chk.sv @@
// Port-level checker for the perceptron trainer, bound to the top level.
// Depends on mlpsb_pkg and mlp_sigmoid_backprop_step.
module mlpsb_chk import mlpsb_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input in_item_t item,
	input logic     busy,
	input logic     done,
	input result_t  result
);

	// a result is only shown once the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// load and unused codes finish in the next cycle
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.func == FUNC_LOAD || item.func == FUNC_NOP)) |=> done)
		else $error("load item gave no result");

	// end of a long item always delivers its result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// class agrees with the activation
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.predicted_class ==
			(result.activation[ACT_W-1] | result.activation[ACT_W-2])))
		else $error("class does not match activation");

	// activation never exceeds one
	a_act_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.activation[ACT_W-1] && (result.activation[ACT_W-2:0] != '0)))
		else $error("activation above one");

endmodule

bind mlp_sigmoid_backprop_step mlpsb_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.item   (item),
	.busy   (busy),
	.done   (done),
	.result (result)
);
